>>> design/tcpoi_pkg.sv
package tcpoi_pkg;

  localparam int MAX_PACKET = 2048;
  localparam int ADDR_W     = $clog2(MAX_PACKET);
  localparam int CNT_W      = $clog2(MAX_PACKET + 4);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_OPTION_KIND  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_OPTION_VALUE = REG_IDX_W'(1);

  localparam logic [7:0]  DEF_OPTION_KIND  = 8'd253;
  localparam logic [15:0] DEF_OPTION_VALUE = 16'd996;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [7:0]  IPV4_VER_IHL = 8'h45;
  localparam logic [7:0]  OPTION_LEN   = 8'd4;
  localparam logic [15:0] TCP_PROTO    = 16'd6;
  localparam logic [3:0]  DOFF_MIN     = 4'd5;
  localparam logic [3:0]  DOFF_BAD     = 4'd15;

  localparam int IP_HDR_BYTES = 20;
  localparam int MIN_PACKET   = 40;
  localparam int OPT_BYTES    = 4;
  localparam int SEG_ADJ      = IP_HDR_BYTES - OPT_BYTES;

  localparam int OFS_TOTLEN_HI  = 2;
  localparam int OFS_TOTLEN_LO  = 3;
  localparam int OFS_IPCSUM_HI  = 10;
  localparam int OFS_IPCSUM_LO  = 11;
  localparam int OFS_PSEUDO     = 12;
  localparam int OFS_DOFF       = 32;
  localparam int OFS_TCPCSUM_HI = 36;
  localparam int OFS_TCPCSUM_LO = 37;

  localparam int OPT_POS_KIND = 0;
  localparam int OPT_POS_LEN  = 1;
  localparam int OPT_POS_VLO  = 2;
  localparam int OPT_POS_VHI  = 3;

  typedef enum logic [2:0] {
    ST_READY     = 3'd0,
    ST_NOT_IPV4  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_OVERSIZE  = 3'd3,
    ST_NOTHING   = 3'd4,
    ST_LOADING   = 3'd5
  } pkt_state_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic       use_ram;
    logic [7:0] byte_val;
    logic       last;
    pkt_state_e status;
  } fetch_meta_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [15:0] csum_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [15:0] csum_fold19(logic [18:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

>>> design/tcp_option_insert_rewriter.sv
// Rewrites one IPv4/TCP packet at a time: load transactions store the packet a byte per
// cycle into a 2048-byte RAM while the IP and TCP checksums accumulate, and fetch
// transactions return the packet with a 4-byte TCP option inserted after the TCP header,
// the total length, data offset and both checksums updated. A transaction is accepted in
// every cycle except while the output register holds a stalled result and a second one
// waits behind it, so a fetch may follow the last load at once; a fetch result passes
// through the first stage, where the RAM's registered read is taken, and then through the
// output register before it is offered.
module tcp_option_insert_rewriter
  import tcpoi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                 ready, acc, issue, cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [7:0]           option_kind_q;
  logic [15:0]          option_value_q;
  ram_req_t             ram_req;
  fetch_meta_t          meta;
  logic [7:0]           rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      option_kind_q  <= DEF_OPTION_KIND;
      option_value_q <= DEF_OPTION_VALUE;
    end else if (cfg_wr) begin
      if (reg_idx == REG_OPTION_KIND) begin
        option_kind_q <= pwdata[7:0];
      end
      if (reg_idx == REG_OPTION_VALUE) begin
        option_value_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OPTION_KIND:  prdata = {{(APB_DATA_W-8){1'b0}}, option_kind_q};
      REG_OPTION_VALUE: prdata = {{(APB_DATA_W-16){1'b0}}, option_value_q};
      default:          prdata = '0;
    endcase
  end

  assign in_stall_o = !ready;
  assign acc        = in_valid_i && ready;

  tcpoi_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .item_i         (in_data_i),
    .option_kind_i  (option_kind_q),
    .option_value_i (option_value_q),
    .ram_req_o      (ram_req),
    .issue_o        (issue),
    .meta_o         (meta)
  );

  tcpoi_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PACKET)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  tcpoi_outstage u_outstage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .meta_i      (meta),
    .rdata_i     (rdata),
    .out_stall_i (out_stall_i),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/tcpoi_ram.sv
module tcpoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tcpoi_core.sv
module tcpoi_core
  import tcpoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  in_item_t    item_i,
  input  logic [7:0]  option_kind_i,
  input  logic [15:0] option_value_i,
  output ram_req_t    ram_req_o,
  output logic        issue_o,
  output fetch_meta_t meta_o
);

  pkt_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, rp_q, rp_d;
  logic [15:0]      ipacc_q, ipacc_d, tcpacc_q, tcpacc_d, tlraw_q, tlraw_d;
  logic [15:0]      ip_sum_q, ip_sum_d, tcp_sum_q, tcp_sum_d, value_q, value_d;
  logic [7:0]       b0_q, b0_d, b32_q, b32_d, kind_q, kind_d;
  logic [3:0]       doff_q, doff_d;
  logic [5:0]       hdr_bytes_q, hdr_bytes_d;

  logic             load_now, new_pkt, ip_hit, tcp_hit, fin;
  logic [CNT_W-1:0] cur_cnt, hdr_c, rp_back, opt_ofs;
  logic [7:0]       in_b, b32_mod, tcp_byte;
  logic [15:0]      ip_base, tcp_base, byte_word, tcp_word;
  logic [15:0]      tl_fin, tl_cur, seg, ip_fin, tcp_fin;
  logic [18:0]      tcp_raw;
  logic [6:0]       hdr_need, hdr_len;
  logic [CNT_W:0]   rp_next_w, total_w;
  logic             rd_re;
  logic [ADDR_W-1:0] rd_addr;

  // Load side: per-byte checksum accumulation with end-around carry.
  assign in_b     = item_i.in_byte;
  assign load_now = acc_i && (item_i.opcode == OP_LOAD);
  assign new_pkt  = (state_q != ST_LOADING);
  assign cur_cnt  = new_pkt ? '0 : cnt_q;
  assign ip_base  = new_pkt ? '0 : ipacc_q;
  assign tcp_base = new_pkt ? '0 : tcpacc_q;

  assign b32_mod   = {in_b[7:4] + 4'd1, in_b[3:0]};
  assign tcp_byte  = (cur_cnt == CNT_W'(OFS_DOFF)) ? b32_mod : in_b;
  assign byte_word = cur_cnt[0] ? {8'h00, in_b} : {in_b, 8'h00};
  assign tcp_word  = cur_cnt[0] ? {8'h00, tcp_byte} : {tcp_byte, 8'h00};

  assign ip_hit = (cur_cnt < CNT_W'(IP_HDR_BYTES))
               && (cur_cnt != CNT_W'(OFS_TOTLEN_HI)) && (cur_cnt != CNT_W'(OFS_TOTLEN_LO))
               && (cur_cnt != CNT_W'(OFS_IPCSUM_HI)) && (cur_cnt != CNT_W'(OFS_IPCSUM_LO));
  assign tcp_hit = (cur_cnt >= CNT_W'(OFS_PSEUDO))
               && (cur_cnt != CNT_W'(OFS_TCPCSUM_HI)) && (cur_cnt != CNT_W'(OFS_TCPCSUM_LO));

  assign ipacc_d  = !load_now ? ipacc_q : (ip_hit ? csum_add(ip_base, byte_word) : ip_base);
  assign tcpacc_d = !load_now ? tcpacc_q
                              : (tcp_hit ? csum_add(tcp_base, tcp_word) : tcp_base);

  assign b0_d  = (load_now && (cur_cnt == '0)) ? in_b : b0_q;
  assign b32_d = (load_now && (cur_cnt == CNT_W'(OFS_DOFF))) ? b32_mod : b32_q;
  assign doff_d = (load_now && (cur_cnt == CNT_W'(OFS_DOFF))) ? in_b[7:4] : doff_q;
  assign tlraw_d[15:8] = (load_now && (cur_cnt == CNT_W'(OFS_TOTLEN_HI))) ? in_b
                                                                            : tlraw_q[15:8];
  assign tlraw_d[7:0]  = (load_now && (cur_cnt == CNT_W'(OFS_TOTLEN_LO))) ? in_b
                                                                            : tlraw_q[7:0];

  // End of packet: close both checksums.
  assign hdr_need = 7'(IP_HDR_BYTES) + {1'b0, doff_d, 2'b00};
  assign tl_fin   = tlraw_d + 16'(OPT_BYTES);
  assign seg      = 16'(cur_cnt + CNT_W'(1) - CNT_W'(SEG_ADJ));
  assign ip_fin   = ~csum_add(ipacc_d, tl_fin);
  assign tcp_raw  = {3'b000, tcpacc_d} + {3'b000, option_kind_i, OPTION_LEN}
                  + {3'b000, option_value_i[7:0], option_value_i[15:8]}
                  + {3'b000, TCP_PROTO} + {3'b000, seg};
  assign tcp_fin  = ~csum_fold19(tcp_raw);

  // Fetch side.
  assign hdr_len   = 7'(IP_HDR_BYTES) + {1'b0, hdr_bytes_q};
  assign hdr_c     = CNT_W'(hdr_len);
  assign tl_cur    = tlraw_q + 16'(OPT_BYTES);
  assign rp_back   = rp_q - CNT_W'(OPT_BYTES);
  assign opt_ofs   = rp_q - hdr_c;
  assign rp_next_w = {1'b0, rp_q} + (CNT_W+1)'(1);
  assign total_w   = {1'b0, cnt_q} + (CNT_W+1)'(OPT_BYTES);
  assign fin       = (rp_next_w >= total_w);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rp_d        = rp_q;
    ip_sum_d    = ip_sum_q;
    tcp_sum_d   = tcp_sum_q;
    hdr_bytes_d = hdr_bytes_q;
    kind_d      = kind_q;
    value_d     = value_q;
    if (load_now) begin
      state_d = ST_LOADING;
      rp_d    = '0;
      cnt_d   = (cur_cnt <= CNT_W'(MAX_PACKET)) ? cur_cnt + CNT_W'(1) : cur_cnt;
      if (item_i.in_last) begin
        if (b0_d != IPV4_VER_IHL) begin
          state_d = ST_NOT_IPV4;
        end else if (cnt_d > CNT_W'(MAX_PACKET)) begin
          state_d = ST_OVERSIZE;
        end else if (cnt_d < CNT_W'(MIN_PACKET)) begin
          state_d = ST_MALFORMED;
        end else if ((doff_d < DOFF_MIN) || (doff_d == DOFF_BAD)
                     || (cnt_d < CNT_W'(hdr_need))) begin
          state_d = ST_MALFORMED;
        end else begin
          state_d     = ST_READY;
          hdr_bytes_d = {doff_d, 2'b00};
          kind_d      = option_kind_i;
          value_d     = option_value_i;
          ip_sum_d    = ip_fin;
          tcp_sum_d   = tcp_fin;
        end
      end
    end else if (acc_i) begin
      case (state_q)
        ST_READY: begin
          rp_d = rp_q + CNT_W'(1);
          if (fin) begin
            state_d = ST_NOTHING;
          end
        end
        ST_NOT_IPV4, ST_MALFORMED, ST_OVERSIZE: begin
          state_d = ST_NOTHING;
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  always_comb begin
    meta_o.use_ram  = 1'b0;
    meta_o.byte_val = 8'h00;
    meta_o.last     = 1'b1;
    meta_o.status   = ST_NOTHING;
    rd_addr         = '0;
    case (state_q)
      ST_READY: begin
        meta_o.last   = fin;
        meta_o.status = ST_READY;
        if (rp_q < hdr_c) begin
          case (rp_q)
            CNT_W'(OFS_TOTLEN_HI):  meta_o.byte_val = tl_cur[15:8];
            CNT_W'(OFS_TOTLEN_LO):  meta_o.byte_val = tl_cur[7:0];
            CNT_W'(OFS_IPCSUM_HI):  meta_o.byte_val = ip_sum_q[15:8];
            CNT_W'(OFS_IPCSUM_LO):  meta_o.byte_val = ip_sum_q[7:0];
            CNT_W'(OFS_DOFF):       meta_o.byte_val = b32_q;
            CNT_W'(OFS_TCPCSUM_HI): meta_o.byte_val = tcp_sum_q[15:8];
            CNT_W'(OFS_TCPCSUM_LO): meta_o.byte_val = tcp_sum_q[7:0];
            default: begin
              meta_o.use_ram = 1'b1;
              rd_addr        = rp_q[ADDR_W-1:0];
            end
          endcase
        end else begin
          case (opt_ofs)
            CNT_W'(OPT_POS_KIND): meta_o.byte_val = kind_q;
            CNT_W'(OPT_POS_LEN):  meta_o.byte_val = OPTION_LEN;
            CNT_W'(OPT_POS_VLO):  meta_o.byte_val = value_q[7:0];
            CNT_W'(OPT_POS_VHI):  meta_o.byte_val = value_q[15:8];
            default: begin
              meta_o.use_ram = 1'b1;
              rd_addr        = rp_back[ADDR_W-1:0];
            end
          endcase
        end
      end
      ST_NOT_IPV4, ST_MALFORMED, ST_OVERSIZE: begin
        meta_o.status = state_q;
      end
      default: begin
        meta_o.status = ST_NOTHING;
      end
    endcase
  end

  assign issue_o = acc_i && (item_i.opcode == OP_FETCH);
  assign rd_re   = issue_o && meta_o.use_ram;

  assign ram_req_o.we    = load_now && (cur_cnt < CNT_W'(MAX_PACKET));
  assign ram_req_o.waddr = cur_cnt[ADDR_W-1:0];
  assign ram_req_o.wdata = in_b;
  assign ram_req_o.re    = rd_re;
  assign ram_req_o.raddr = rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NOTHING;
      cnt_q   <= '0;
      rp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rp_q    <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ipacc_q     <= ipacc_d;
    tcpacc_q    <= tcpacc_d;
    tlraw_q     <= tlraw_d;
    ip_sum_q    <= ip_sum_d;
    tcp_sum_q   <= tcp_sum_d;
    value_q     <= value_d;
    b0_q        <= b0_d;
    b32_q       <= b32_d;
    kind_q      <= kind_d;
    doff_q      <= doff_d;
    hdr_bytes_q <= hdr_bytes_d;
  end

endmodule

>>> design/tcpoi_outstage.sv
module tcpoi_outstage
  import tcpoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        issue_i,
  input  fetch_meta_t meta_i,
  input  logic [7:0]  rdata_i,
  input  logic        out_stall_i,
  output logic        ready_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o
);

  logic        s1_valid_q, s1_valid_d;
  fetch_meta_t s1_meta_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;
  logic        adv;

  assign adv     = !out_valid_q || !out_stall_i;
  assign ready_o = !s1_valid_q || adv;

  assign s1_valid_d  = ready_o ? issue_i : s1_valid_q;
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;

  always_comb begin
    out_data_d = out_data_q;
    if (adv) begin
      out_data_d.out_byte = s1_meta_q.use_ram ? rdata_i : s1_meta_q.byte_val;
      out_data_d.out_last = s1_meta_q.last;
      out_data_d.status   = s1_meta_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && issue_i) begin
      s1_meta_q <= meta_i;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
